// ===== hw/rtl/udasc_pkg.sv =====
// Shared types and constants for the unsigned binary to decimal ASCII converter.
package udasc_pkg;

    localparam int IN_W = 32;
    localparam int CHAR_W = 6;
    localparam int DIGIT_W = 4;
    localparam int DEC_BASE = 10;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } udasc_cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic cnt_one;
    } udasc_stat_t;

endpackage

// ===== hw/rtl/udasc_ctrl.sv =====
// Controller state machine that sequences load, digit extraction and character output.
module udasc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output udasc_pkg::udasc_cmd_t  cmd,
    input  udasc_pkg::udasc_stat_t stat
);
    import udasc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIVIDE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.step = 1'b1;
                if (stat.quot_zero) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.cnt_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/udasc_datapath.sv =====
// Datapath with the reciprocal divide-by-ten loop, digit buffer and output register.
module udasc_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic [udasc_pkg::IN_W-1:0]   s_value,
    input  udasc_pkg::udasc_cmd_t        cmd,
    output udasc_pkg::udasc_stat_t       stat,
    output logic [udasc_pkg::CHAR_W-1:0] m_character,
    output logic                         m_last
);
    import udasc_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam int SHIFT = W + 3;
    localparam int NUM_DIGITS = ((W * 1233) >> 12) + 1;
    localparam int CNT_W = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W = $clog2(NUM_DIGITS);
    localparam logic [SHIFT:0] POW = {1'b1, {SHIFT{1'b0}}};
    localparam logic [SHIFT:0] RECIP_WIDE = POW / DEC_BASE + 1;
    localparam logic [W-1:0] RECIP = RECIP_WIDE[W-1:0];

    logic [W-1:0]       v_in;
    logic [2*W-1:0]     prod_reg, prod_next;
    logic [W-1:0]       prev_reg;
    logic [W-1:0]       quot;
    logic [W-1:0]       mul_a;
    logic [DIGIT_W-1:0] quot_x10_lo;
    logic [DIGIT_W-1:0] digit;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_dec;
    logic [DIGIT_W-1:0] digit_buf_reg [NUM_DIGITS];
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    genvar gi;
    generate
        for (gi = 0; gi < W; gi++) begin : g_vin
            if (gi < IN_W) begin : g_bit
                assign v_in[gi] = s_value[gi];
            end else begin : g_zero
                assign v_in[gi] = 1'b0;
            end
        end
    endgenerate

    assign quot        = {3'b000, prod_reg[2*W-1:SHIFT]};
    assign mul_a       = cmd.load ? v_in : quot;
    assign prod_next   = mul_a * RECIP;
    assign quot_x10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign digit       = prev_reg[DIGIT_W-1:0] - quot_x10_lo;
    assign cnt_dec     = cnt_reg - 1'b1;

    assign stat.quot_zero = (quot == '0);
    assign stat.cnt_one   = (cnt_reg == CNT_W'(1));

    assign m_character = char_reg;
    assign m_last      = last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            prod_reg <= prod_next;
            prev_reg <= v_in;
            cnt_reg  <= '0;
        end else if (cmd.step) begin
            prod_reg                      <= prod_next;
            prev_reg                      <= quot;
            digit_buf_reg[cnt_reg[IDX_W-1:0]] <= digit;
            cnt_reg                       <= cnt_reg + 1'b1;
        end else if (cmd.emit) begin
            char_reg <= ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}},
                                      digit_buf_reg[cnt_dec[IDX_W-1:0]]};
            last_reg <= (cnt_reg == CNT_W'(1));
            cnt_reg  <= cnt_dec;
        end
    end

endmodule

// ===== hw/rtl/unsigned_to_decimal_ascii.sv =====
// Top level of the unsigned binary to decimal ASCII converter.
// An item with n decimal digits makes n passes through the divide-by-ten loop, one
// reciprocal multiply per digit, then sends one character per cycle while m_ready holds.
// A new item is taken only when the controller is back in idle, after the last
// character of the previous item has been loaded into the output register.
// Synchronous active-low reset returns the controller to idle and drops m_valid.
module unsigned_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [udasc_pkg::IN_W-1:0]   s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [udasc_pkg::CHAR_W-1:0] m_character,
    output logic                         m_last
);
    import udasc_pkg::*;

    udasc_cmd_t  cmd;
    udasc_stat_t stat;

    udasc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    udasc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .s_value     (s_value),
        .cmd         (cmd),
        .stat        (stat),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule
